/* rtl/core/dqsr_pkg.sv */
`default_nettype none

package dqsr_pkg;

  // Default configuration
  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed payload widths
  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT  = 3'd0,
    OP_ADD_BACK   = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_CONTAINS   = 3'd6,
    OP_REMOVE     = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  // Logical position that the store read port looks at
  typedef enum logic [1:0] {
    RD_FRONT,
    RD_BACK,
    RD_NEXT,
    RD_NEXT2
  } rd_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic    take;
    logic    do_add;
    logic    flag;
    status_t flag_code;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    capture;
    logic    set_found;
    logic    scan_step;
    logic    shift_write;
    logic    drop_one;
    logic    load_out;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic hit;
    logic scan_last;
    logic shift_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/dqsr_req_if.sv */
`default_nettype none

interface dqsr_req_if;
  logic                            valid;
  logic                            ready;
  logic [dqsr_pkg::OP_W-1:0]       operation;
  logic signed [dqsr_pkg::DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

/* rtl/core/dqsr_rsp_if.sv */
`default_nettype none

interface dqsr_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [dqsr_pkg::DATA_W-1:0] data_out;
  logic                               found;
  logic [dqsr_pkg::STATUS_W-1:0]      status;
  logic [dqsr_pkg::COUNT_W-1:0]       count_out;

  modport source (output valid, output data_out, output found, output status,
                  output count_out, input ready);
  modport sink   (input valid, input data_out, input found, input status,
                  input count_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/deque_with_search_and_remove.sv */
// Channel   Dir   Fields                               Beat when
// req       in    operation, value                     req.valid && req.ready
// rsp       out   data_out, found, status, count_out   rsp.valid && rsp.ready
//
// Adds, and operations flagged on a full or empty store, pass from EXEC straight to DONE;
// pop and peek pass through READ between them (one registered read of the store).
// Contains stops at the first match from the front or at the back; remove searches the
// same way and on a hit closes the gap: the search and the gap closing walk the store
// one entry a cycle through its single read port. A new beat is taken once the previous
// result is registered, even while it still waits on rsp.ready.
// Synchronous reset empties the store at once; entries need no clearing.
`default_nettype none

module deque_with_search_and_remove #(
  parameter int DEPTH       = dqsr_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = dqsr_pkg::VALUE_WIDTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  dqsr_req_if.sink  req,
  dqsr_rsp_if.source rsp
);

  dqsr_pkg::ctl_t ctl;
  dqsr_pkg::sts_t sts;

  dqsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  dqsr_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .req_operation (req.operation),
    .req_value     (req.value),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .rsp_data_out  (rsp.data_out),
    .rsp_found     (rsp.found),
    .rsp_status    (rsp.status),
    .rsp_count_out (rsp.count_out)
  );

endmodule

`default_nettype wire

/* rtl/core/dqsr_ram.sv */
`default_nettype none

module dqsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, held while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dqsr_ctrl.sv */
`default_nettype none

module dqsr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire dqsr_pkg::sts_t sts,
  output dqsr_pkg::ctl_t      ctl
);

  dqsr_pkg::state_t state;
  dqsr_pkg::state_t state_next;

  logic is_add;
  logic is_read;
  logic is_front;

  assign is_add   = (sts.op == dqsr_pkg::OP_ADD_FRONT) || (sts.op == dqsr_pkg::OP_ADD_BACK);
  assign is_read  = (sts.op == dqsr_pkg::OP_POP_FRONT) || (sts.op == dqsr_pkg::OP_POP_BACK)
                 || (sts.op == dqsr_pkg::OP_PEEK_FRONT) || (sts.op == dqsr_pkg::OP_PEEK_BACK);
  assign is_front = (sts.op == dqsr_pkg::OP_POP_FRONT) || (sts.op == dqsr_pkg::OP_PEEK_FRONT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dqsr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dqsr_pkg::S_IDLE: begin
        if (req_valid) state_next = dqsr_pkg::S_EXEC;
      end
      dqsr_pkg::S_EXEC: begin
        if (is_add || sts.empty) state_next = dqsr_pkg::S_DONE;
        else if (is_read)        state_next = dqsr_pkg::S_READ;
        else                     state_next = dqsr_pkg::S_SCAN;
      end
      dqsr_pkg::S_READ: begin
        state_next = dqsr_pkg::S_DONE;
      end
      dqsr_pkg::S_SCAN: begin
        if (sts.hit) begin
          if (sts.op == dqsr_pkg::OP_CONTAINS || sts.scan_last) state_next = dqsr_pkg::S_DONE;
          else                                                   state_next = dqsr_pkg::S_SHIFT;
        end else if (sts.scan_last) begin
          state_next = dqsr_pkg::S_DONE;
        end
      end
      dqsr_pkg::S_SHIFT: begin
        if (sts.shift_last) state_next = dqsr_pkg::S_DONE;
      end
      dqsr_pkg::S_DONE: begin
        if (sts.out_free) state_next = dqsr_pkg::S_IDLE;
      end
      default: state_next = dqsr_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    req_ready = 1'b0;
    ctl       = '0;
    ctl.flag_code = dqsr_pkg::ST_OK;
    ctl.rd_sel    = dqsr_pkg::RD_FRONT;
    case (state)
      dqsr_pkg::S_IDLE: begin
        req_ready = 1'b1;
        ctl.take  = req_valid;
      end
      dqsr_pkg::S_EXEC: begin
        if (is_add) begin
          if (sts.full) begin
            ctl.flag      = 1'b1;
            ctl.flag_code = dqsr_pkg::ST_FULL;
          end else begin
            ctl.do_add = 1'b1;
          end
        end else if (sts.empty) begin
          ctl.flag      = 1'b1;
          ctl.flag_code = dqsr_pkg::ST_EMPTY;
        end else begin
          // end reads pick their side, searches start at the front
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = (is_read && !is_front) ? dqsr_pkg::RD_BACK : dqsr_pkg::RD_FRONT;
        end
      end
      dqsr_pkg::S_READ: begin
        ctl.capture = 1'b1;
      end
      dqsr_pkg::S_SCAN: begin
        if (sts.hit) begin
          ctl.set_found = 1'b1;
          if (sts.op == dqsr_pkg::OP_REMOVE) begin
            if (sts.scan_last) begin
              ctl.drop_one = 1'b1;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = dqsr_pkg::RD_NEXT;
            end
          end
        end else if (sts.scan_last) begin
          if (sts.op == dqsr_pkg::OP_REMOVE) begin
            ctl.flag      = 1'b1;
            ctl.flag_code = dqsr_pkg::ST_MISSING;
          end
        end else begin
          ctl.rd_en     = 1'b1;
          ctl.rd_sel    = dqsr_pkg::RD_NEXT;
          ctl.scan_step = 1'b1;
        end
      end
      dqsr_pkg::S_SHIFT: begin
        ctl.shift_write = 1'b1;
        if (sts.shift_last) begin
          ctl.drop_one = 1'b1;
        end else begin
          ctl.rd_en     = 1'b1;
          ctl.rd_sel    = dqsr_pkg::RD_NEXT2;
          ctl.scan_step = 1'b1;
        end
      end
      dqsr_pkg::S_DONE: begin
        ctl.load_out = sts.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/dqsr_datapath.sv */
`default_nettype none

module dqsr_datapath #(
  parameter int DEPTH       = dqsr_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = dqsr_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire dqsr_pkg::ctl_t                      ctl,
  output dqsr_pkg::sts_t                           sts,
  input  wire logic [dqsr_pkg::OP_W-1:0]           req_operation,
  input  wire logic signed [dqsr_pkg::DATA_W-1:0]  req_value,
  input  wire logic                                rsp_ready,
  output logic                                     rsp_valid,
  output logic signed [dqsr_pkg::DATA_W-1:0]       rsp_data_out,
  output logic                                     rsp_found,
  output logic [dqsr_pkg::STATUS_W-1:0]            rsp_status,
  output logic [dqsr_pkg::COUNT_W-1:0]             rsp_count_out
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int DW = dqsr_pkg::DATA_W;
  localparam int XW = VALUE_WIDTH + DW;

  // Map a position counted from the front onto a store address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(l);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[AW-1:0];
  endfunction

  dqsr_pkg::op_t     op;
  logic [VALUE_WIDTH-1:0] key;
  logic [AW-1:0]     head;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [DW-1:0]     res_data;
  logic              res_found;
  dqsr_pkg::status_t res_status;
  logic              out_valid;

  logic [XW-1:0]          val_ext;
  logic [VALUE_WIDTH-1:0] key_in;
  logic [XW-1:0]          rd_ext;
  logic [AW-1:0]          head_inc;
  logic [AW-1:0]          head_dec;
  logic [SW-1:0]          idx_p1;
  logic [SW-1:0]          idx_p2;
  logic [CW-1:0]          rd_pos;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [CW+4:0]          count_ext;

  // Key is the sign-extended input cut to the stored width
  assign val_ext = {{VALUE_WIDTH{req_value[DW-1]}}, req_value};
  assign key_in  = val_ext[VALUE_WIDTH-1:0];
  assign rd_ext  = {{DW{rd_data[VALUE_WIDTH-1]}}, rd_data};

  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign idx_p1   = SW'(idx) + SW'(1);
  assign idx_p2   = SW'(idx) + SW'(2);

  // Read address
  always_comb begin
    case (ctl.rd_sel)
      dqsr_pkg::RD_FRONT: rd_pos = '0;
      dqsr_pkg::RD_BACK:  rd_pos = count - CW'(1);
      dqsr_pkg::RD_NEXT:  rd_pos = idx_p1[CW-1:0];
      dqsr_pkg::RD_NEXT2: rd_pos = idx_p2[CW-1:0];
      default:            rd_pos = '0;
    endcase
  end
  assign rd_addr = phys(head, rd_pos);

  // Write address: new end entry, or close the gap one place
  always_comb begin
    wr_en   = ctl.do_add || ctl.shift_write;
    wr_data = ctl.shift_write ? rd_data : key;
    if (ctl.shift_write)                   wr_addr = phys(head, idx);
    else if (op == dqsr_pkg::OP_ADD_FRONT) wr_addr = head_dec;
    else                                   wr_addr = phys(head, count);
  end

  dqsr_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Status to controller
  assign sts.op         = op;
  assign sts.full       = (count == CW'(DEPTH));
  assign sts.empty      = (count == '0);
  assign sts.hit        = (rd_data == key);
  assign sts.scan_last  = (idx_p1 >= SW'(count));
  assign sts.shift_last = (idx_p2 >= SW'(count));
  assign sts.out_free   = !out_valid || rsp_ready;

  // Store pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.do_add) begin
      count <= count + CW'(1);
      if (op == dqsr_pkg::OP_ADD_FRONT) head <= head_dec;
    end else if (ctl.capture) begin
      if (op == dqsr_pkg::OP_POP_FRONT) begin
        head  <= head_inc;
        count <= count - CW'(1);
      end else if (op == dqsr_pkg::OP_POP_BACK) begin
        count <= count - CW'(1);
      end
    end else if (ctl.drop_one) begin
      count <= count - CW'(1);
    end
  end

  // Operation, scan position and result
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      op         <= dqsr_pkg::op_t'(req_operation);
      key        <= key_in;
      idx        <= '0;
      res_data   <= '0;
      res_found  <= 1'b0;
      res_status <= dqsr_pkg::ST_OK;
    end else begin
      if (ctl.scan_step) idx <= idx + CW'(1);
      if (ctl.flag)      res_status <= ctl.flag_code;
      if (ctl.capture)   res_data <= rd_ext[DW-1:0];
      if (ctl.set_found) res_found <= 1'b1;
    end
  end

  // Output register
  assign count_ext = (CW + 5)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      rsp_data_out  <= res_data;
      rsp_found     <= res_found;
      rsp_status    <= res_status;
      rsp_count_out <= count_ext[dqsr_pkg::COUNT_W-1:0];
    end
  end

  assign rsp_valid = out_valid;

endmodule

`default_nettype wire

/* rtl/core/dqsr_check.sv */
`default_nettype none

module dqsr_check (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               req_valid,
  input wire logic                               req_ready,
  input wire logic                               rsp_valid,
  input wire logic                               rsp_ready,
  input wire logic [dqsr_pkg::DATA_W-1:0]        rsp_data_out,
  input wire logic                               rsp_found,
  input wire logic [dqsr_pkg::STATUS_W-1:0]      rsp_status,
  input wire logic [dqsr_pkg::COUNT_W-1:0]       rsp_count_out
);

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result still valid after reset");

  // A stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_found)
      && $stable(rsp_status) && $stable(rsp_count_out))
    else $error("stalled result changed");

  // One operation at a time: no second beat straight after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // No result can appear in the cycle after a request beat
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("result too early");

endmodule

bind deque_with_search_and_remove dqsr_check u_check (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_data_out  (rsp.data_out),
  .rsp_found     (rsp.found),
  .rsp_status    (rsp.status),
  .rsp_count_out (rsp.count_out)
);

`default_nettype wire

/* tb/deque_with_search_and_remove_test.sv */
`default_nettype none

module deque_with_search_and_remove_test;
  import dqsr_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_TAIL   = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic               found;
    status_t            status;
    logic [COUNT_W-1:0] count_out;
  } deque_rsp_t;

  typedef struct {
    op_t         op;
    logic [31:0] val;
    int          reps;
    bit          typed;
    deque_rsp_t  want;
  } stim_row_t;

  logic clk;
  logic rst;

  dqsr_req_if req_ch ();
  dqsr_rsp_if rsp_ch ();

  deque_with_search_and_remove uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Predicted store contents, front first, and results still to arrive
  logic [DATA_W-1:0] held_q[$];
  deque_rsp_t        awaited_q[$];
  stim_row_t         stim_table[$];

  int  fail_count;
  bit  rsp_stalls_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  // Work out the result of one operation and update the predicted store
  function automatic deque_rsp_t apply_op(op_t op, logic [DATA_W-1:0] val);
    deque_rsp_t r;
    int hit;
    int i;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    if (op == OP_ADD_FRONT || op == OP_ADD_BACK) begin
      if (held_q.size() >= DEPTH) r.status = ST_FULL;
      else if (op == OP_ADD_FRONT) held_q.push_front(val);
      else held_q.push_back(val);
    end else if (held_q.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      case (op)
        OP_POP_FRONT:  r.data_out = held_q.pop_front();
        OP_POP_BACK:   r.data_out = held_q.pop_back();
        OP_PEEK_FRONT: r.data_out = held_q[0];
        OP_PEEK_BACK:  r.data_out = held_q[held_q.size() - 1];
        default: begin
          // frontmost match only
          for (i = 0; i < held_q.size() && hit < 0; i++)
            if (held_q[i] == val) hit = i;
          r.found = (hit >= 0);
          if (op == OP_REMOVE) begin
            if (hit >= 0) held_q.delete(hit);
            else r.status = ST_MISSING;
          end
        end
      endcase
    end
    r.count_out = COUNT_W'(held_q.size());
    return r;
  endfunction

  function automatic deque_rsp_t mk_rsp(logic [31:0] data, logic found, status_t st,
                                        int count);
    deque_rsp_t r;
    r.data_out  = data;
    r.found     = found;
    r.status    = st;
    r.count_out = COUNT_W'(count);
    return r;
  endfunction

  task automatic add_row(op_t op, logic [31:0] val, int reps, bit typed, deque_rsp_t want);
    stim_row_t row;
    row.op    = op;
    row.val   = val;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  // Present one beat and hold it until taken; log the expectation on acceptance
  task automatic send_beat(op_t op, logic [31:0] val, bit typed, deque_rsp_t want);
    deque_rsp_t got;
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value     <= val;
    do @(posedge clk); while (!req_ch.ready);
    got = apply_op(op, val);
    awaited_q.push_back(typed ? want : got);
  endtask

  task automatic idle_gap();
    req_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 3)) @(posedge clk);
  endtask

  // Values that tend to collide, plus the signed extremes
  function automatic logic [31:0] pool_value();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  function automatic logic [31:0] pick_value(op_t op);
    int roll;
    roll = $urandom_range(0, 99);
    if (op == OP_CONTAINS || op == OP_REMOVE) begin
      if (roll < 60 && held_q.size() != 0) return held_q[$urandom_range(0, held_q.size() - 1)];
      if (roll < 85) return pool_value();
      return $urandom;
    end
    if (roll < 50) return pool_value();
    return $urandom;
  endfunction

  // Bias the operation mix so the store swings between full and empty
  function automatic op_t pick_op(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (roll < 70) return roll[0] ? OP_ADD_BACK : OP_ADD_FRONT;
        return op_t'($urandom_range(2, 7));
      end
      1: begin
        if (roll < 25) return OP_POP_FRONT;
        if (roll < 45) return OP_POP_BACK;
        if (roll < 65) return OP_REMOVE;
        return op_t'($urandom_range(0, 7));
      end
      default: return op_t'($urandom_range(0, 7));
    endcase
  endfunction

  // Sink side: stall in short bursts while enabled
  initial begin
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    deque_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result beat: data %h found %b status %0d count %0d",
                   rsp_ch.data_out, rsp_ch.found, rsp_ch.status, rsp_ch.count_out);
      end else begin
        want = awaited_q.pop_front();
        if (rsp_ch.data_out !== want.data_out || rsp_ch.found !== want.found ||
            rsp_ch.status !== want.status || rsp_ch.count_out !== want.count_out) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display({"mismatch: want data %h found %b status %0d count %0d, ",
                      "got data %h found %b status %0d count %0d"},
                     want.data_out, want.found, want.status, want.count_out,
                     rsp_ch.data_out, rsp_ch.found, rsp_ch.status, rsp_ch.count_out);
        end
      end
    end
  end

  initial begin
    deque_rsp_t none;
    int issued;
    int mode;
    int seg_len;
    int k;
    int r;
    bit gappy;
    op_t op;

    none          = '0;
    fail_count    = 0;
    rsp_stalls_on = 1'b0;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_ADD_FRONT;
    req_ch.value     <= '0;

    // Empty store: every read-side operation is flagged
    add_row(OP_POP_FRONT,  32'h0,  1, 1, mk_rsp(32'h0, 1'b0, ST_EMPTY, 0));
    add_row(OP_POP_BACK,   32'h0,  1, 1, mk_rsp(32'h0, 1'b0, ST_EMPTY, 0));
    add_row(OP_PEEK_FRONT, 32'h0,  1, 1, mk_rsp(32'h0, 1'b0, ST_EMPTY, 0));
    add_row(OP_PEEK_BACK,  32'h0,  1, 1, mk_rsp(32'h0, 1'b0, ST_EMPTY, 0));
    add_row(OP_CONTAINS,   32'h0,  1, 1, mk_rsp(32'h0, 1'b0, ST_EMPTY, 0));
    add_row(OP_REMOVE,     32'h0,  1, 1, mk_rsp(32'h0, 1'b0, ST_EMPTY, 0));
    // Fill to the brim, extremes at either end
    add_row(OP_ADD_BACK,   32'hFFFF_FFFF, 14, 0, none);
    add_row(OP_ADD_FRONT,  32'h7FFF_FFFF, 1, 1, mk_rsp(32'h0, 1'b0, ST_OK, 15));
    add_row(OP_ADD_BACK,   32'h8000_0000, 1, 1, mk_rsp(32'h0, 1'b0, ST_OK, DEPTH));
    // Full store: adds are flagged and change nothing; peeks, contains and remove still work
    add_row(OP_ADD_BACK,   32'h0, 1, 1, mk_rsp(32'h0, 1'b0, ST_FULL, DEPTH));
    add_row(OP_ADD_FRONT,  32'h0, 1, 1, mk_rsp(32'h0, 1'b0, ST_FULL, DEPTH));
    add_row(OP_PEEK_FRONT, 32'h0, 1, 1, mk_rsp(32'h7FFF_FFFF, 1'b0, ST_OK, DEPTH));
    add_row(OP_PEEK_BACK,  32'h0, 1, 1, mk_rsp(32'h8000_0000, 1'b0, ST_OK, DEPTH));
    add_row(OP_CONTAINS,   32'h8000_0000, 1, 1, mk_rsp(32'h0, 1'b1, ST_OK, DEPTH));
    add_row(OP_REMOVE,     32'h7FFF_FFFF, 1, 1, mk_rsp(32'h0, 1'b1, ST_OK, 15));
    // A miss on contains is a plain answer; a miss on remove is flagged
    add_row(OP_CONTAINS,   32'h7FFF_FFFF, 1, 1, mk_rsp(32'h0, 1'b0, ST_OK, 15));
    add_row(OP_REMOVE,     32'h7FFF_FFFF, 1, 1, mk_rsp(32'h0, 1'b0, ST_MISSING, 15));
    add_row(OP_POP_BACK,   32'h0, 1, 0, none);
    add_row(OP_REMOVE,     32'hFFFF_FFFF, 1, 0, none);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (stim_table[i])
      for (k = 0; k < stim_table[i].reps; k++)
        send_beat(stim_table[i].op, stim_table[i].val, stim_table[i].typed,
                  stim_table[i].want);

    // Random segments, each with its own operation mix and idling
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      mode    = $urandom_range(0, 2);
      seg_len = $urandom_range(20, 60);
      gappy   = $urandom_range(0, 1);
      rsp_stalls_on = $urandom_range(0, 1) && (issued < RANDOM_ITEMS - QUIET_TAIL);
      for (r = 0; r < seg_len && issued < RANDOM_ITEMS; r++) begin
        if (issued >= RANDOM_ITEMS - QUIET_TAIL) begin
          gappy         = 1'b0;
          rsp_stalls_on = 1'b0;
        end
        if (gappy && $urandom_range(0, 3) == 0) idle_gap();
        op = pick_op(mode);
        send_beat(op, pick_value(op), 1'b0, none);
        issued++;
      end
    end
    req_ch.valid <= 1'b0;

    // Drain, then watch for stray beats
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && awaited_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
